[sv/gcwf_pkg.sv]
`timescale 1ns / 1ps
// Types, codes and decode functions for the GPU command-word framer.
// No dependencies; imported by gpu_command_word_framer.

package gcwf_pkg;

    // Parser phase after each word
    typedef enum logic [1:0] {
        PH_COMMAND  = 2'd0,
        PH_PARAMS   = 2'd1,
        PH_UPLOAD   = 2'd2,
        PH_POLYLINE = 2'd3
    } phase_t;

    // Status condition to wait on before the word moves
    typedef enum logic [2:0] {
        WAIT_NONE       = 3'd0,
        WAIT_CMD_READY  = 3'd1,
        WAIT_FIFO_EMPTY = 3'd2,
        WAIT_NOT_FULL   = 3'd3,
        WAIT_READ_READY = 3'd4
    } wait_kind_t;

    // Item kinds on the input tuser
    localparam logic [1:0] ACT_DATA    = 2'd0;
    localparam logic [1:0] ACT_CONTROL = 2'd1;
    localparam logic [1:0] ACT_DISCARD = 2'd2;

    // Control-port ops
    localparam logic [5:0] CTL_RESET     = 6'h00;
    localparam logic [5:0] CTL_CLR_FIFO  = 6'h01;
    localparam logic [5:0] CTL_DMA_MODE  = 6'h04;

    // Command classes (opcode bits 7..5)
    localparam logic [2:0] CLS_CPU_TO_VRAM = 3'd5;
    localparam logic [2:0] CLS_VRAM_TO_CPU = 3'd6;

    localparam logic [7:0]  POLY_MASK  = 8'he8;
    localparam logic [7:0]  POLY_MATCH = 8'h48;
    localparam logic [31:0] TERM_MASK  = 32'hf000f000;
    localparam logic [31:0] TERM_MATCH = 32'h50005000;
    localparam logic [1:0]  DMA_POLY   = 2'd1;

    localparam int CNT_W = 19;

    // Result item, wait_kind in the lowest bits
    typedef struct packed {
        logic       terminator_seen;
        phase_t     parser_phase;
        logic [1:0] status_dma_mode;
        logic       status_write_needed;
        wait_kind_t wait_kind;
    } result_t;

    // Parameter words that follow a command opcode
    function automatic logic [3:0] param_count(input logic [7:0] op);
        logic [3:0] v;
        logic [3:0] col;
        logic [3:0] cnt;
        v   = op[3] ? 4'd4 : 4'd3;
        col = op[4] ? (v - 4'd1) : 4'd0;
        cnt = 4'd0;
        case (op[7:5])
            3'd0: cnt = (op == 8'h02) ? 4'd2 : 4'd0;
            3'd1: cnt = (op[2] ? {v[2:0], 1'b0} : v) + col;
            3'd2: cnt = op[4] ? 4'd3 : 4'd2;
            3'd3: cnt = 4'd1 + {3'd0, op[2]} + {3'd0, (op[4:3] == 2'b00)};
            3'd4: cnt = 4'd3;
            3'd5: cnt = 4'd2;
            3'd6: cnt = 4'd2;
            default: cnt = 4'd0;
        endcase
        return cnt;
    endfunction

    // 32-bit word count of a width x height halfword transfer, rounded up
    function automatic logic [CNT_W-1:0] xfer_words(input logic [31:0] size);
        logic [10:0] w;
        logic [9:0]  h;
        logic [20:0] prod;
        logic [21:0] sum;
        w    = {1'b0, size[9:0] - 10'd1} + 11'd1;
        h    = {1'b0, size[24:16] - 9'd1} + 10'd1;
        prod = w * h;
        sum  = {1'b0, prod} + 22'd1;
        return sum[CNT_W:1];
    endfunction

endpackage

[sv/gpu_command_word_framer.sv]
`timescale 1ns / 1ps
// GPU command-word framer: input register, decode/state stage, result register.
// Two register stages (input register, result register); one word per cycle sustained unless the
// output stalls. The state update and the 11x10-bit transfer-size multiply sit between the
// input and result registers. Each stage stalls only when the stage after it is full and stalled.
// Reset (rst_n low, asynchronous): both stages empty, parser in command phase, all counters zero.
// Depends on gcwf_pkg.

module gpu_command_word_framer
    import gcwf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [31:0] word, [33:32] current_dma_dir, rest zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [2:0] wait_kind, [3] status_write_needed,
                                       // [5:4] status_dma_mode, [7:6] parser_phase,
                                       // [8] terminator_seen, rest zero
);

    // ---------------- input register ----------------
    logic        in_valid_reg;
    logic [1:0]  act_reg;
    logic [31:0] word_reg;
    logic [1:0]  dir_reg;

    // ---------------- result register ----------------
    logic        out_valid_reg;
    result_t     res_reg;

    // ---------------- framer state ----------------
    phase_t           phase_reg,  phase_next;
    logic [7:0]       opcode_reg, opcode_next;
    logic [CNT_W-1:0] left_reg,   left_next;
    logic [CNT_W-1:0] rdback_reg, rdback_next;
    logic [1:0]       pidx_reg,   pidx_next;
    logic             podd_reg,   podd_next;
    logic [1:0]       saved_reg,  saved_next;

    result_t          res_next;
    logic             advance;     // input stage moves into result stage
    logic             can_term;
    logic [CNT_W-1:0] left_dec;
    logic [CNT_W-1:0] xfer_cnt;
    logic [5:0]       ctl_op;

    // A word leaves the input register when the result register is free or draining.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            act_reg  <= s_axis_tuser;
            word_reg <= s_axis_tdata[31:0];
            dir_reg  <= s_axis_tdata[33:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_COMMAND;
            opcode_reg <= 8'd0;
            left_reg   <= '0;
            rdback_reg <= '0;
            pidx_reg   <= 2'd0;
            podd_reg   <= 1'b0;
            saved_reg  <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            left_reg   <= left_next;
            rdback_reg <= rdback_next;
            pidx_reg   <= pidx_next;
            podd_reg   <= podd_next;
            saved_reg  <= saved_next;
        end
    end

    assign left_dec = left_reg - 1'b1;
    assign xfer_cnt = xfer_words(word_reg);
    assign ctl_op   = word_reg[29:24];

    // Gouraud polylines end only on the first word of a vertex (odd word index).
    assign can_term = opcode_reg[4] ? (pidx_reg == 2'd3 && podd_reg) : (pidx_reg >= 2'd2);

    // Next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        left_next   = left_reg;
        rdback_next = rdback_reg;
        pidx_next   = pidx_reg;
        podd_next   = podd_reg;
        saved_next  = saved_reg;
        res_next    = '0;

        if (advance)
        begin
            case (act_reg)
                ACT_DATA:
                begin
                    case (phase_reg)
                        PH_COMMAND:
                        begin
                            res_next.wait_kind = WAIT_CMD_READY;
                            opcode_next = word_reg[31:24];
                            if ((word_reg[31:24] & POLY_MASK) == POLY_MATCH)
                            begin
                                saved_next = dir_reg;
                                res_next.status_write_needed = 1'b1;
                                res_next.status_dma_mode     = DMA_POLY;
                                pidx_next  = 2'd0;
                                podd_next  = 1'b0;
                                phase_next = PH_POLYLINE;
                            end
                            else
                            begin
                                left_next = {{(CNT_W-4){1'b0}}, param_count(word_reg[31:24])};
                                if (param_count(word_reg[31:24]) != 4'd0)
                                begin
                                    phase_next = PH_PARAMS;
                                end
                            end
                        end
                        PH_PARAMS:
                        begin
                            res_next.wait_kind = WAIT_NONE;
                            left_next = left_dec;
                            if (left_dec == '0)
                            begin
                                phase_next = PH_COMMAND;
                                if (opcode_reg[7:5] == CLS_CPU_TO_VRAM)
                                begin
                                    left_next  = xfer_cnt;
                                    phase_next = PH_UPLOAD;
                                end
                                else if (opcode_reg[7:5] == CLS_VRAM_TO_CPU)
                                begin
                                    rdback_next = xfer_cnt;
                                end
                            end
                        end
                        PH_UPLOAD:
                        begin
                            res_next.wait_kind = WAIT_FIFO_EMPTY;
                            left_next = left_dec;
                            if (left_dec == '0)
                            begin
                                phase_next = PH_COMMAND;
                            end
                        end
                        default:
                        begin
                            res_next.wait_kind = WAIT_NOT_FULL;
                            if (pidx_reg != 2'd3)
                            begin
                                pidx_next = pidx_reg + 2'd1;
                            end
                            podd_next = !podd_reg;
                            if (can_term && ((word_reg & TERM_MASK) == TERM_MATCH))
                            begin
                                res_next.terminator_seen     = 1'b1;
                                res_next.status_write_needed = 1'b1;
                                res_next.status_dma_mode     = saved_reg;
                                phase_next = PH_COMMAND;
                            end
                        end
                    endcase
                end
                ACT_CONTROL:
                begin
                    if (ctl_op == CTL_RESET || ctl_op == CTL_CLR_FIFO)
                    begin
                        phase_next  = PH_COMMAND;
                        left_next   = '0;
                        rdback_next = '0;
                    end
                    else if (ctl_op == CTL_DMA_MODE && phase_reg == PH_POLYLINE)
                    begin
                        saved_next = word_reg[1:0];
                        res_next.status_write_needed = 1'b1;
                        res_next.status_dma_mode     = DMA_POLY;
                    end
                end
                ACT_DISCARD:
                begin
                    if (rdback_reg != '0)
                    begin
                        res_next.wait_kind = WAIT_READ_READY;
                        rdback_next = rdback_reg - 1'b1;
                    end
                end
                default:
                begin
                    // unknown kind: no state change
                end
            endcase
            res_next.parser_phase = phase_next;
        end
    end

    // ---------------- assertions ----------------
    // A terminator always asks for the mode restore and lands in command phase.
    a_term_restore: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_reg.terminator_seen) |->
            (res_reg.status_write_needed && res_reg.parser_phase == PH_COMMAND))
        else $error("terminator without restore write or phase return");

    // Mode field is zero unless a status write is requested.
    a_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !res_reg.status_write_needed) |-> (res_reg.status_dma_mode == 2'd0))
        else $error("DMA mode set without status write");

    // Parameter or upload phase never sits on an empty counter.
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PARAMS || phase_reg == PH_UPLOAD) |-> (left_reg != '0))
        else $error("parameter/upload phase with zero words left");

    // The readback counter never grows on a discard.
    a_rdback_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && act_reg == ACT_DISCARD) |=> (rdback_reg <= $past(rdback_reg)))
        else $error("readback counter grew on a discard");

endmodule
